// ===== design/qft_pkg.sv =====
// ----------------------------------------------------------------------------
// qft_pkg
// Shared types and constants for the quoted field tokenizer.
// ----------------------------------------------------------------------------
package qft_pkg;

    localparam int unsigned MAX_FIELDS_DEFAULT = 255;
    localparam int unsigned RESULT_DEPTH       = 4;
    localparam int unsigned RESULT_AW          = $clog2(RESULT_DEPTH);

    localparam logic [7:0] QUOTE_BYTE     = 8'h22;
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;

    typedef enum logic [2:0] {
        KIND_CONT  = 3'd0,
        KIND_START = 3'd1,
        KIND_END   = 3'd2,
        KIND_EMPTY = 3'd3,
        KIND_DONE  = 3'd4,
        KIND_ERROR = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BACKSLASH = 2'd1,
        ERR_QUOTE     = 2'd2
    } err_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_out;
        logic [7:0] field_number;
        err_t       error_code;
        logic       last;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// ===== design/qft_core.sv =====
// ----------------------------------------------------------------------------
// qft_core
// Tokenizer state flags, field counter and per-beat result generation.
// ----------------------------------------------------------------------------
module qft_core #(
    parameter int unsigned MAX_FIELDS = qft_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  logic [7:0]       char_byte,
    input  logic             end_of_line,
    output logic [1:0]       push_n,
    output qft_pkg::result_t res0,
    output qft_pkg::result_t res1
);

    localparam logic [7:0] COUNT_LIMIT =
        (MAX_FIELDS > 255) ? 8'd255 : ((MAX_FIELDS < 1) ? 8'd1 : MAX_FIELDS[7:0]);

    logic       field_reg, field_next;
    logic       quotes_reg, quotes_next;
    logic       esc_reg, esc_next;
    logic [7:0] cnt_reg, cnt_next;

    logic [7:0]       cur_idx;
    logic [7:0]       cnt_inc;
    logic [7:0]       start_idx;
    qft_pkg::result_t r0, r1, fin, emit;
    logic [1:0]       n;

    always_comb begin
        cur_idx   = cnt_reg - 8'd1;
        cnt_inc   = (cnt_reg < COUNT_LIMIT) ? cnt_reg + 8'd1 : cnt_reg;
        start_idx = cnt_inc - 8'd1;

        fin = '{kind: qft_pkg::KIND_DONE, char_out: 8'd0, field_number: cnt_reg,
                error_code: qft_pkg::ERR_NONE, last: 1'b1};
        if (esc_reg) begin
            fin.kind         = qft_pkg::KIND_ERROR;
            fin.field_number = 8'd0;
            fin.error_code   = qft_pkg::ERR_BACKSLASH;
        end else if (quotes_reg) begin
            fin.kind         = qft_pkg::KIND_ERROR;
            fin.field_number = 8'd0;
            fin.error_code   = qft_pkg::ERR_QUOTE;
        end

        emit = '{kind: qft_pkg::KIND_CONT, char_out: char_byte, field_number: cur_idx,
                 error_code: qft_pkg::ERR_NONE, last: 1'b1};
        if (!field_reg) begin
            emit.kind         = qft_pkg::KIND_START;
            emit.field_number = start_idx;
        end

        r0 = '{kind: qft_pkg::KIND_END, char_out: 8'd0, field_number: cur_idx,
               error_code: qft_pkg::ERR_NONE, last: 1'b1};
        r1          = fin;
        n           = 2'd0;
        field_next  = field_reg;
        quotes_next = quotes_reg;
        esc_next    = esc_reg;
        cnt_next    = cnt_reg;

        if (end_of_line) begin
            if (field_reg) begin
                r0.last = 1'b0;
                n       = 2'd2;
            end else begin
                r0 = fin;
                n  = 2'd1;
            end
            field_next  = 1'b0;
            quotes_next = 1'b0;
            esc_next    = 1'b0;
            cnt_next    = 8'd0;
        end else if (esc_reg) begin
            esc_next   = 1'b0;
            r0         = emit;
            n          = 2'd1;
            field_next = 1'b1;
            if (!field_reg) cnt_next = cnt_inc;
        end else if (qft_pkg::is_space(char_byte) && !quotes_reg) begin
            if (field_reg) begin
                n          = 2'd1;
                field_next = 1'b0;
            end
        end else if (char_byte == qft_pkg::QUOTE_BYTE) begin
            if (quotes_reg) begin
                n = 2'd1;
                if (!field_reg) begin
                    r0.kind         = qft_pkg::KIND_EMPTY;
                    r0.field_number = start_idx;
                    cnt_next        = cnt_inc;
                end
                field_next  = 1'b0;
                quotes_next = 1'b0;
            end else begin
                quotes_next = 1'b1;
            end
        end else if (char_byte == qft_pkg::BACKSLASH_BYTE && quotes_reg) begin
            esc_next = 1'b1;
        end else begin
            r0         = emit;
            n          = 2'd1;
            field_next = 1'b1;
            if (!field_reg) cnt_next = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg  <= 1'b0;
            quotes_reg <= 1'b0;
            esc_reg    <= 1'b0;
            cnt_reg    <= 8'd0;
        end else if (take) begin
            field_reg  <= field_next;
            quotes_reg <= quotes_next;
            esc_reg    <= esc_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign push_n = take ? n : 2'd0;
    assign res0   = r0;
    assign res1   = r1;

    a_esc_in_quotes: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> quotes_reg)
        else $error("escape pending outside quotes");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= COUNT_LIMIT)
        else $error("field counter above limit");

    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && end_of_line |=> !field_reg && !quotes_reg && !esc_reg && cnt_reg == 8'd0)
        else $error("state not cleared after end of line");

endmodule

// ===== design/qft_out_fifo.sv =====
// ----------------------------------------------------------------------------
// qft_out_fifo
// Small result queue taking up to two result beats per cycle, one out.
// ----------------------------------------------------------------------------
module qft_out_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_n,
    input  qft_pkg::result_t res0,
    input  qft_pkg::result_t res1,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output qft_pkg::result_t m_data
);

    localparam int unsigned DEPTH = qft_pkg::RESULT_DEPTH;
    localparam int unsigned AW    = qft_pkg::RESULT_AW;

    qft_pkg::result_t mem [DEPTH];

    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW:0]   count_reg, count_next;
    logic          pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rp_reg];
    assign room    = (count_reg <= (AW+1)'(DEPTH - 2));

    always_comb begin
        wp_next    = wp_reg + AW'(push_n);
        rp_next    = rp_reg + AW'(pop);
        count_next = count_reg + (AW+1)'(push_n) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) mem[wp_reg] <= res0;
        if (push_n == 2'd2) mem[wp_reg + AW'(1)] <= res1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end else begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_n != 2'd0 |-> room)
        else $error("push without room");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        AW'(wp_reg - rp_reg) == count_reg[AW-1:0])
        else $error("pointer gap disagrees with count");

endmodule

// ===== design/quoted_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_field_tokenizer
// Splits a command line, one byte per beat, into quoted or blank-separated
// fields.
// ----------------------------------------------------------------------------
// Each input beat carries one byte or an end-of-line marker. A byte beat is
// handled in the cycle it is accepted and gives zero or one result beat; an
// end-of-line beat gives one or two (field end, then done or error) and
// clears the tokenizer state. Results go through a four-entry queue, so the
// block takes one input beat per cycle while results drain at one per
// cycle; s_ready drops only when the queue cannot hold two more results,
// which happens when the output side stalls or an end-of-line beat closes
// an open field. The field count saturates at MAX_FIELDS clamped to 1..255.
module quoted_field_tokenizer #(
    parameter int unsigned MAX_FIELDS = qft_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_byte,
    input  logic       s_end_of_line,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_char_out,
    output logic [7:0] m_field_number,
    output logic [1:0] m_error_code,
    output logic       m_last
);

    logic             take;
    logic             room;
    logic [1:0]       push_n;
    qft_pkg::result_t res0, res1, m_data;

    assign s_ready = room;
    assign take    = s_valid && room;

    qft_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .char_byte   (s_char_byte),
        .end_of_line (s_end_of_line),
        .push_n      (push_n),
        .res0        (res0),
        .res1        (res1)
    );

    qft_out_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .res0    (res0),
        .res1    (res1),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign m_kind         = m_data.kind;
    assign m_char_out     = m_data.char_out;
    assign m_field_number = m_data.field_number;
    assign m_error_code   = m_data.error_code;
    assign m_last         = m_data.last;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quoted field tokenizer. A directed line set hits
// whitespace, quoting, escapes, empty fields and both errors; random lines,
// mostly well formed with some broken ones, follow under three idle profiles,
// one line long enough to saturate the field count. A scoreboard predicts the
// result beats of every accepted input beat and checks them in order.
// ----------------------------------------------------------------------------
class token_scoreboard;
    int unsigned      field_limit;
    bit               field_open;
    bit               quote_open;
    bit               escaped;
    int unsigned      fields_begun;
    qft_pkg::result_t expected_tokens[$];
    qft_pkg::result_t fresh[$];
    int               failures;

    function new(int unsigned limit);
        field_limit = limit;
        failures    = 0;
        clear_line();
    endfunction

    function void clear_line();
        field_open   = 1'b0;
        quote_open   = 1'b0;
        escaped      = 1'b0;
        fields_begun = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function logic [7:0] begin_field();
        if (fields_begun < field_limit) fields_begun++;
        return 8'(fields_begun - 1);
    endfunction

    function logic [7:0] open_index();
        return 8'(fields_begun - 1);
    endfunction

    function void emit(qft_pkg::kind_t k, logic [7:0] ch, logic [7:0] num,
                       qft_pkg::err_t e);
        qft_pkg::result_t r;
        r.kind         = k;
        r.char_out     = ch;
        r.field_number = num;
        r.error_code   = e;
        r.last         = 1'b0;
        fresh.push_back(r);
    endfunction

    function void take_char(logic [7:0] c);
        if (!field_open) begin
            field_open = 1'b1;
            emit(qft_pkg::KIND_START, c, begin_field(), qft_pkg::ERR_NONE);
        end else begin
            emit(qft_pkg::KIND_CONT, c, open_index(), qft_pkg::ERR_NONE);
        end
    endfunction

    function void note_beat(logic [7:0] c, logic eol);
        fresh.delete();
        if (eol) begin
            if (field_open)
                emit(qft_pkg::KIND_END, 8'h00, open_index(), qft_pkg::ERR_NONE);
            if (escaped)
                emit(qft_pkg::KIND_ERROR, 8'h00, 8'h00, qft_pkg::ERR_BACKSLASH);
            else if (quote_open)
                emit(qft_pkg::KIND_ERROR, 8'h00, 8'h00, qft_pkg::ERR_QUOTE);
            else
                emit(qft_pkg::KIND_DONE, 8'h00, 8'(fields_begun), qft_pkg::ERR_NONE);
            clear_line();
        end else if (escaped) begin
            escaped = 1'b0;
            take_char(c);
        end else if (is_blank(c) && !quote_open) begin
            if (field_open) begin
                emit(qft_pkg::KIND_END, 8'h00, open_index(), qft_pkg::ERR_NONE);
                field_open = 1'b0;
            end
        end else if (c == qft_pkg::QUOTE_BYTE) begin
            if (quote_open) begin
                if (field_open)
                    emit(qft_pkg::KIND_END, 8'h00, open_index(), qft_pkg::ERR_NONE);
                else
                    emit(qft_pkg::KIND_EMPTY, 8'h00, begin_field(), qft_pkg::ERR_NONE);
                field_open = 1'b0;
                quote_open = 1'b0;
            end else begin
                quote_open = 1'b1;
            end
        end else if (c == qft_pkg::BACKSLASH_BYTE && quote_open) begin
            escaped = 1'b1;
        end else begin
            take_char(c);
        end
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i]) expected_tokens.push_back(fresh[i]);
    endfunction

    function int pending();
        return expected_tokens.size();
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_token(logic [2:0] kind, logic [7:0] ch, logic [7:0] num,
                              logic [1:0] err, logic last);
        qft_pkg::result_t want;
        if (expected_tokens.size() == 0) begin
            $error("result beat with none expected: kind %0d", kind);
            failures++;
            return;
        end
        want = expected_tokens.pop_front();
        compare_field("kind", 8'(want.kind), 8'(kind));
        compare_field("char_out", want.char_out, ch);
        compare_field("field_number", want.field_number, num);
        compare_field("error_code", 8'(want.error_code), 8'(err));
        compare_field("last", 8'(want.last), 8'(last));
    endfunction
endclass

module tb;
    localparam int unsigned MAX_FIELDS  = qft_pkg::MAX_FIELDS_DEFAULT;
    localparam int unsigned FIELD_LIMIT = (MAX_FIELDS > 255) ? 255 :
                                          ((MAX_FIELDS < 1) ? 1 : MAX_FIELDS);
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PHASE_BEATS = 360;
    localparam logic [8:0]  QB          = {1'b0, qft_pkg::QUOTE_BYTE};
    localparam logic [8:0]  BS          = {1'b0, qft_pkg::BACKSLASH_BYTE};
    localparam logic [8:0]  EOL_MARK    = 9'h1C3;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_byte   = 8'h00;
    logic       s_end_of_line = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_char_out;
    logic [7:0] m_field_number;
    logic [1:0] m_error_code;
    logic       m_last;

    int          send_idle   = 27;
    int          recv_idle   = 72;
    int unsigned items_sent  = 0;
    int unsigned idle_cycles = 0;
    logic [8:0]  line_beats[$];

    token_scoreboard sb = new(FIELD_LIMIT);

    quoted_field_tokenizer #(.MAX_FIELDS(MAX_FIELDS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_byte   (s_char_byte),
        .s_end_of_line (s_end_of_line),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_char_out    (m_char_out),
        .m_field_number(m_field_number),
        .m_error_code  (m_error_code),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // input beats are noted before result beats are checked
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_beat(s_char_byte, s_end_of_line);
        if (aresetn && m_valid && m_ready)
            sb.check_token(m_kind, m_char_out, m_field_number, m_error_code, m_last);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** quoted_field_tokenizer: FAILED **");
            $finish;
        end
    end

    function automatic void push_byte(logic [7:0] b);
        line_beats.push_back({1'b0, b});
    endfunction

    function automatic void push_eol();
        line_beats.push_back({1'b1, 8'($urandom_range(255))});
    endfunction

    function automatic logic [7:0] pick_blank();
        int unsigned n;
        n = $urandom_range(5);
        return (n == 5) ? 8'h20 : 8'(8'h09 + n);
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == qft_pkg::QUOTE_BYTE || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D));
        return b;
    endfunction

    function automatic logic [7:0] pick_inner();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == qft_pkg::QUOTE_BYTE || b == qft_pkg::BACKSLASH_BYTE);
        return b;
    endfunction

    function automatic void add_blanks(int unsigned n);
        repeat (n) push_byte(pick_blank());
    endfunction

    function automatic void add_word();
        repeat ($urandom_range(4, 1)) push_byte(pick_plain());
    endfunction

    function automatic void add_quoted();
        push_byte(qft_pkg::QUOTE_BYTE);
        repeat ($urandom_range(4)) begin
            if ($urandom_range(3) == 0) begin
                push_byte(qft_pkg::BACKSLASH_BYTE);
                push_byte(8'($urandom_range(255)));
            end else begin
                push_byte(pick_inner());
            end
        end
        push_byte(qft_pkg::QUOTE_BYTE);
    endfunction

    function automatic void build_line();
        int unsigned tokens;
        int unsigned ending;
        line_beats.delete();
        add_blanks($urandom_range(2));
        tokens = $urandom_range(6);
        for (int t = 0; t < tokens; t++) begin
            if (t > 0) add_blanks($urandom_range(3, 1));
            case ($urandom_range(4))
                0: add_word();
                1: add_quoted();
                2: begin
                    add_word();
                    add_quoted();
                end
                3: begin
                    add_quoted();
                    add_word();
                end
                default: begin
                    add_word();
                    add_quoted();
                    add_word();
                end
            endcase
        end
        add_blanks($urandom_range(2));
        ending = $urandom_range(9);
        // unterminated quote, backslash at end, or raw noise
        if (ending == 7 || ending == 8) begin
            push_byte(qft_pkg::QUOTE_BYTE);
            repeat ($urandom_range(3)) push_byte(pick_inner());
            if (ending == 8) push_byte(qft_pkg::BACKSLASH_BYTE);
        end else if (ending == 9) begin
            repeat ($urandom_range(8, 1)) push_byte(8'($urandom_range(255)));
        end
        push_eol();
    endfunction

    function automatic void build_saturating_line();
        line_beats.delete();
        repeat (FIELD_LIMIT + $urandom_range(12, 2)) begin
            if ($urandom_range(1) == 0) begin
                push_byte(qft_pkg::QUOTE_BYTE);
                push_byte(qft_pkg::QUOTE_BYTE);
            end else begin
                push_byte(pick_plain());
                push_byte(pick_blank());
            end
        end
        push_eol();
    endfunction

    task automatic send_beat(input logic [8:0] beat);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_byte   <= beat[7:0];
        s_end_of_line <= beat[8];
        do @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    task automatic send_line();
        foreach (line_beats[i]) send_beat(line_beats[i]);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic run_random(input int unsigned beats, input bit with_saturation);
        int unsigned target;
        target = items_sent + beats;
        if (with_saturation) begin
            build_saturating_line();
            send_line();
        end
        while (items_sent < target) begin
            build_line();
            send_line();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // escapes, blanks, empty quotes, both errors, empty line, near-blank bytes
        line_beats = '{9'h000, 9'h0FF, 9'h020, 9'h009, 9'h00D, QB, BS, QB, 9'h00B,
                       QB, QB, QB, BS, 9'h041, EOL_MARK,
                       QB, BS, EOL_MARK,
                       QB, 9'h061, EOL_MARK,
                       EOL_MARK,
                       9'h008, 9'h00A, 9'h00E, 9'h00C, EOL_MARK};
        send_line();
        wait_drained();

        run_random(PHASE_BEATS, 1'b0);
        wait_drained();

        send_idle = 72;
        recv_idle = 27;
        run_random(PHASE_BEATS, 1'b1);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        run_random(PHASE_BEATS, 1'b0);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("** quoted_field_tokenizer: PASSED **");
        end else begin
            $display("** quoted_field_tokenizer: FAILED **");
        end
        $finish;
    end
endmodule
